// ===== rtl/rc_serial_frame_parser_core_assert.svh =====
// ----------------------------------------------------------------------------
// RC serial frame parser assertion macros
// Shared concurrent assertion forms for the frame parser checks.
// ----------------------------------------------------------------------------
`ifndef RC_SERIAL_FRAME_PARSER_CORE_ASSERT_SVH
`define RC_SERIAL_FRAME_PARSER_CORE_ASSERT_SVH

// Overlapping implication: when ante holds, cons holds in the same cycle.
`define RCSFP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rc serial frame parser assertion failed");

// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define RCSFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rc serial frame parser assertion failed");

`endif

// ===== rtl/rcsfp_pkg.sv =====
// ----------------------------------------------------------------------------
// RC serial frame parser package
// Constants, state encoding and shared types of the frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rcsfp_pkg;

  localparam int unsigned Channels    = 7;
  localparam int unsigned MaxChannels = 7;
  localparam int unsigned DataLen     = 2 * Channels;
  localparam int unsigned StoreDepth  = DataLen - 1;
  localparam int unsigned IdxW        = (DataLen > 1) ? $clog2(DataLen) : 1;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned ChanW       = 10;
  localparam int unsigned HighBits    = ChanW - ByteW;
  localparam int unsigned FrameNumW   = 32;

  localparam logic [ByteW-1:0] PreFirst  = 8'h03;
  localparam logic [ByteW-1:0] PreSecond = 8'h01;

  typedef enum logic [2:0] {
    StHunt = 3'b001,
    StSync = 3'b010,
    StData = 3'b100
  } state_e;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
  } byte_req_t;

  typedef struct packed {
    logic [MaxChannels-1:0][ChanW-1:0] chan;
    logic [FrameNumW-1:0]              frame_number;
  } frame_t;

endpackage

`default_nettype wire

// ===== rtl/rcsfp_byte_if.sv =====
// ----------------------------------------------------------------------------
// RC serial frame parser byte channel
// Valid/ready channel that carries one received byte per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcsfp_byte_if;
  logic                        valid;
  logic                        ready;
  logic [rcsfp_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/rcsfp_frame_if.sv =====
// ----------------------------------------------------------------------------
// RC serial frame parser frame channel
// Valid/ready channel that carries one decoded frame per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcsfp_frame_if;
  logic                            valid;
  logic                            ready;
  logic [rcsfp_pkg::ChanW-1:0]     chan0;
  logic [rcsfp_pkg::ChanW-1:0]     chan1;
  logic [rcsfp_pkg::ChanW-1:0]     chan2;
  logic [rcsfp_pkg::ChanW-1:0]     chan3;
  logic [rcsfp_pkg::ChanW-1:0]     chan4;
  logic [rcsfp_pkg::ChanW-1:0]     chan5;
  logic [rcsfp_pkg::ChanW-1:0]     chan6;
  logic [rcsfp_pkg::FrameNumW-1:0] frame_number;

  modport source (
    output valid, output chan0, output chan1, output chan2, output chan3,
    output chan4, output chan5, output chan6, output frame_number,
    input ready
  );
  modport sink (
    input valid, input chan0, input chan1, input chan2, input chan3,
    input chan4, input chan5, input chan6, input frame_number,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/rcsfp_in_stage.sv =====
// ----------------------------------------------------------------------------
// RC serial frame parser input register
// Holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rcsfp_in_stage (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  input  wire logic [rcsfp_pkg::ByteW-1:0] data_i,
  output logic                             ready_o,
  output rcsfp_pkg::byte_req_t             req_o,
  input  wire logic                        take_i
);

  logic                        valid_q, valid_d;
  logic [rcsfp_pkg::ByteW-1:0] data_q;
  logic                        load;

  assign ready_o = !valid_q || take_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_i;
    end
  end

  assign req_o.valid = valid_q;
  assign req_o.data  = data_q;

endmodule

`default_nettype wire

// ===== rtl/rcsfp_parser.sv =====
// ----------------------------------------------------------------------------
// RC serial frame parser core logic
// Preamble hunt, data byte store, channel assembly and frame count.
// ----------------------------------------------------------------------------
`default_nettype none

module rcsfp_parser (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire rcsfp_pkg::byte_req_t req_i,
  output logic                      take_o,
  input  wire logic                 space_i,
  output logic                      res_valid_o,
  output rcsfp_pkg::frame_t         res_o
);

  rcsfp_pkg::state_e                state_q, state_d;
  logic [rcsfp_pkg::IdxW-1:0]       idx_q, idx_d;
  logic [rcsfp_pkg::FrameNumW-1:0]  count_q, count_d;
  logic [rcsfp_pkg::ByteW-1:0]      bytes_q [rcsfp_pkg::StoreDepth];
  logic                             is_last;
  logic                             emit;

  assign is_last = (state_q == rcsfp_pkg::StData) &&
                   (idx_q == rcsfp_pkg::IdxW'(rcsfp_pkg::DataLen - 1));
  assign take_o  = req_i.valid && (!is_last || space_i);
  assign emit    = req_i.valid && is_last && space_i;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    count_d = count_q;
    if (take_o) begin
      case (state_q)
        rcsfp_pkg::StHunt: begin
          if (req_i.data == rcsfp_pkg::PreFirst) begin
            state_d = rcsfp_pkg::StSync;
          end
        end
        rcsfp_pkg::StSync: begin
          idx_d = '0;
          if (req_i.data == rcsfp_pkg::PreSecond) begin
            state_d = rcsfp_pkg::StData;
          end else begin
            state_d = rcsfp_pkg::StHunt;
          end
        end
        rcsfp_pkg::StData: begin
          if (is_last) begin
            state_d = rcsfp_pkg::StHunt;
            count_d = count_q + rcsfp_pkg::FrameNumW'(1);
          end else begin
            idx_d = idx_q + rcsfp_pkg::IdxW'(1);
          end
        end
        default: begin
          state_d = rcsfp_pkg::StHunt;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcsfp_pkg::StHunt;
      idx_q   <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      count_q <= count_d;
    end
  end

  for (genvar i = 0; i < rcsfp_pkg::StoreDepth; i++) begin : g_store
    always_ff @(posedge clk_i) begin
      if (take_o && (state_q == rcsfp_pkg::StData) &&
          (idx_q == rcsfp_pkg::IdxW'(i))) begin
        bytes_q[i] <= req_i.data;
      end
    end
  end

  for (genvar k = 0; k < rcsfp_pkg::MaxChannels; k++) begin : g_chan
    if (k >= rcsfp_pkg::Channels) begin : g_unused
      assign res_o.chan[k] = '0;
    end else if (2 * k + 1 == rcsfp_pkg::DataLen - 1) begin : g_tail
      assign res_o.chan[k] = {bytes_q[2*k][rcsfp_pkg::HighBits-1:0], req_i.data};
    end else begin : g_body
      assign res_o.chan[k] = {bytes_q[2*k][rcsfp_pkg::HighBits-1:0], bytes_q[2*k+1]};
    end
  end

  assign res_o.frame_number = count_q + rcsfp_pkg::FrameNumW'(1);
  assign res_valid_o        = emit;

endmodule

`default_nettype wire

// ===== rtl/rcsfp_out_stage.sv =====
// ----------------------------------------------------------------------------
// RC serial frame parser result register
// Holds one decoded frame until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rcsfp_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              res_valid_i,
  input  wire rcsfp_pkg::frame_t res_i,
  output logic                   space_o,
  output logic                   valid_o,
  output rcsfp_pkg::frame_t      frame_o,
  input  wire logic              ready_i
);

  logic              valid_q, valid_d;
  rcsfp_pkg::frame_t frame_q;

  assign space_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (res_valid_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      frame_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign frame_o = frame_q;

endmodule

`default_nettype wire

// ===== rtl/rc_serial_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// RC serial frame parser
// Finds the 0x03 0x01 preamble in a byte stream, collects the data bytes of
// one frame and emits the decoded channel values with a frame count.
//
//   channel   dir  payload                          per request
//   rx_i      in   rx_byte                          one received byte
//   frame_o   out  chan0..chan6, frame_number       one complete frame
//
// One byte is taken every cycle unless a frame's last byte waits for space;
// a frame leaves through the input register, then the result register.
// The result register frees the input side while a frame waits downstream.
// A stalled frame stops only the last byte of the next frame.
// Reset returns the parser to preamble hunting and clears the frame count.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_serial_frame_parser_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rcsfp_byte_if.sink    rx_i,
  rcsfp_frame_if.source frame_o
);

  rcsfp_pkg::byte_req_t req;
  rcsfp_pkg::frame_t    res;
  rcsfp_pkg::frame_t    frame;
  logic                 take;
  logic                 space;
  logic                 res_valid;
  logic                 in_ready;
  logic                 out_valid;

  rcsfp_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rx_i.valid),
    .data_i  (rx_i.rx_byte),
    .ready_o (in_ready),
    .req_o   (req),
    .take_i  (take)
  );

  rcsfp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .take_o      (take),
    .space_i     (space),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  rcsfp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .space_o     (space),
    .valid_o     (out_valid),
    .frame_o     (frame),
    .ready_i     (frame_o.ready)
  );

  assign rx_i.ready           = in_ready;
  assign frame_o.valid        = out_valid;
  assign frame_o.chan0        = frame.chan[0];
  assign frame_o.chan1        = frame.chan[1];
  assign frame_o.chan2        = frame.chan[2];
  assign frame_o.chan3        = frame.chan[3];
  assign frame_o.chan4        = frame.chan[4];
  assign frame_o.chan5        = frame.chan[5];
  assign frame_o.chan6        = frame.chan[6];
  assign frame_o.frame_number = frame.frame_number;

endmodule

`default_nettype wire

// ===== rtl/rcsfp_checker.sv =====
// ----------------------------------------------------------------------------
// RC serial frame parser checker
// Port-level checks on the frame channel and the frame count sequence.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rc_serial_frame_parser_core_assert.svh"

module rcsfp_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            out_valid_i,
  input wire logic                            out_ready_i,
  input wire logic [rcsfp_pkg::ChanW-1:0]     chan0_i,
  input wire logic [rcsfp_pkg::FrameNumW-1:0] frame_number_i
);

  logic                            seen_q;
  logic [rcsfp_pkg::FrameNumW-1:0] last_q;
  logic                            out_acc;

  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      last_q <= '0;
    end else if (out_acc) begin
      seen_q <= 1'b1;
      last_q <= frame_number_i;
    end
  end

  `RCSFP_ASSERT_NEXT(a_out_valid_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `RCSFP_ASSERT_NEXT(a_out_data_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(frame_number_i) && $stable(chan0_i))
  `RCSFP_ASSERT_NOW(a_first_frame, clk_i, rst_ni, out_acc && !seen_q, frame_number_i == rcsfp_pkg::FrameNumW'(1))
  `RCSFP_ASSERT_NOW(a_frame_step, clk_i, rst_ni, out_acc && seen_q, frame_number_i == rcsfp_pkg::FrameNumW'(last_q + rcsfp_pkg::FrameNumW'(1)))

endmodule

bind rc_serial_frame_parser_core rcsfp_checker u_rcsfp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (frame_o.valid),
  .out_ready_i    (frame_o.ready),
  .chan0_i        (frame_o.chan0),
  .frame_number_i (frame_o.frame_number)
);

`default_nettype wire
